>>> sv/lfr_pkg.sv
`timescale 1ns / 1ps

package lfr_pkg;

    localparam int BYTE_W = 8;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int CTRL_CODES = 8;
    localparam int PHASE_W = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_INDEX_W-1:0] REG_FLAG_VALUE       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SENDER_ADDRESS   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RECEIVER_ADDRESS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CONTROL_CODES    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CONTROL_NINTH    = 3'd4;

    localparam logic [BYTE_W-1:0]     FLAG_VALUE_RESET       = 8'd126;
    localparam logic [BYTE_W-1:0]     SENDER_ADDRESS_RESET   = 8'd3;
    localparam logic [BYTE_W-1:0]     RECEIVER_ADDRESS_RESET = 8'd1;
    localparam logic [CFG_DATA_W-1:0] CONTROL_CODES_RESET    = 64'd423883291691779;
    localparam logic [BYTE_W-1:0]     CONTROL_NINTH_RESET    = 8'd64;

    localparam logic [PHASE_W-1:0] PHASE_IDLE    = 3'd0;
    localparam logic [PHASE_W-1:0] PHASE_FLAG    = 3'd1;
    localparam logic [PHASE_W-1:0] PHASE_ADDRESS = 3'd2;
    localparam logic [PHASE_W-1:0] PHASE_CONTROL = 3'd3;
    localparam logic [PHASE_W-1:0] PHASE_CHECKED = 3'd4;
    localparam logic [PHASE_W-1:0] PHASE_DATA    = 3'd5;
    localparam logic [PHASE_W-1:0] PHASE_DONE    = 3'd6;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_FLAG    = 6'b000010,
        ST_ADDRESS = 6'b000100,
        ST_CONTROL = 6'b001000,
        ST_CHECKED = 6'b010000,
        ST_DATA    = 6'b100000
    } frame_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              is_flag;
        logic              is_address;
        logic              is_control;
    } class_entry_t;

    typedef struct packed {
        logic [PHASE_W-1:0] frame_phase;
        logic               store_valid;
        logic [BYTE_W-1:0]  store_position;
        logic [BYTE_W-1:0]  store_value;
        logic               frame_done;
        logic               overflow;
    } frame_result_t;

endpackage

>>> sv/lfr_classify.sv
`timescale 1ns / 1ps

module lfr_classify (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [lfr_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [lfr_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic [lfr_pkg::BYTE_W-1:0]            rx_byte,
    output lfr_pkg::class_entry_t                 entry
);

    logic [lfr_pkg::BYTE_W-1:0]     flag_value_reg;
    logic [lfr_pkg::BYTE_W-1:0]     sender_address_reg;
    logic [lfr_pkg::BYTE_W-1:0]     receiver_address_reg;
    logic [lfr_pkg::CFG_DATA_W-1:0] control_codes_reg;
    logic [lfr_pkg::BYTE_W-1:0]     control_ninth_reg;
    logic [lfr_pkg::CTRL_CODES-1:0] code_hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_value_reg       <= lfr_pkg::FLAG_VALUE_RESET;
            sender_address_reg   <= lfr_pkg::SENDER_ADDRESS_RESET;
            receiver_address_reg <= lfr_pkg::RECEIVER_ADDRESS_RESET;
            control_codes_reg    <= lfr_pkg::CONTROL_CODES_RESET;
            control_ninth_reg    <= lfr_pkg::CONTROL_NINTH_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                lfr_pkg::REG_FLAG_VALUE: begin
                    flag_value_reg <= cfg_data[lfr_pkg::BYTE_W-1:0];
                end
                lfr_pkg::REG_SENDER_ADDRESS: begin
                    sender_address_reg <= cfg_data[lfr_pkg::BYTE_W-1:0];
                end
                lfr_pkg::REG_RECEIVER_ADDRESS: begin
                    receiver_address_reg <= cfg_data[lfr_pkg::BYTE_W-1:0];
                end
                lfr_pkg::REG_CONTROL_CODES: begin
                    control_codes_reg <= cfg_data;
                end
                lfr_pkg::REG_CONTROL_NINTH: begin
                    control_ninth_reg <= cfg_data[lfr_pkg::BYTE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < lfr_pkg::CTRL_CODES; k++) begin
            code_hit[k] = (control_codes_reg[k*lfr_pkg::BYTE_W +: lfr_pkg::BYTE_W] == rx_byte);
        end
    end

    always_comb begin
        entry.rx_byte    = rx_byte;
        entry.is_flag    = (rx_byte == flag_value_reg);
        entry.is_address = (rx_byte == sender_address_reg) ||
                           (rx_byte == receiver_address_reg);
        entry.is_control = (|code_hit) || (rx_byte == control_ninth_reg);
    end

endmodule

>>> sv/lfr_queue.sv
`timescale 1ns / 1ps

module lfr_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  lfr_pkg::class_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output logic                  not_empty,
    output lfr_pkg::class_entry_t head_entry
);

    lfr_pkg::class_entry_t                slot_reg [lfr_pkg::QUEUE_DEPTH];
    logic [lfr_pkg::QUEUE_PTR_W-1:0]      wr_ptr_reg;
    logic [lfr_pkg::QUEUE_PTR_W-1:0]      rd_ptr_reg;
    logic [lfr_pkg::QUEUE_CNT_W-1:0]      count_reg;

    assign full       = (count_reg == lfr_pkg::QUEUE_CNT_W'(lfr_pkg::QUEUE_DEPTH));
    assign not_empty  = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> sv/lfr_sequencer.sv
`timescale 1ns / 1ps

module lfr_sequencer #(
    parameter int FRAME_CAPACITY = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  entry_valid,
    input  lfr_pkg::class_entry_t entry,
    output logic                  entry_pop,
    output logic                  result_valid,
    input  logic                  result_ready,
    output lfr_pkg::frame_result_t result
);

    localparam int POS_W = $clog2(FRAME_CAPACITY + 1);
    localparam logic [POS_W-1:0] CAPACITY = POS_W'(FRAME_CAPACITY);

    lfr_pkg::frame_state_t           state_reg, state_next;
    logic [POS_W-1:0]                position_reg, position_next;
    logic [lfr_pkg::BYTE_W-1:0]      address_reg, address_next;
    logic [lfr_pkg::BYTE_W-1:0]      control_reg, control_next;
    logic                            valid_reg, valid_next;
    lfr_pkg::frame_result_t          result_reg, result_next;

    logic                            store;
    logic [lfr_pkg::PHASE_W-1:0]     target;
    logic [POS_W+lfr_pkg::BYTE_W-1:0] position_ext;

    assign entry_pop    = entry_valid && (!valid_reg || result_ready);
    assign result_valid = valid_reg;
    assign result       = result_reg;
    assign position_ext = (POS_W + lfr_pkg::BYTE_W)'(position_reg);

    always_comb begin
        store  = 1'b0;
        target = lfr_pkg::PHASE_IDLE;
        case (state_reg)
            lfr_pkg::ST_IDLE: begin
                if (entry.is_flag) begin
                    store  = 1'b1;
                    target = lfr_pkg::PHASE_FLAG;
                end
            end
            lfr_pkg::ST_FLAG: begin
                if (entry.is_flag) begin
                    target = lfr_pkg::PHASE_FLAG;
                end else if (entry.is_address) begin
                    store  = 1'b1;
                    target = lfr_pkg::PHASE_ADDRESS;
                end
            end
            lfr_pkg::ST_ADDRESS: begin
                if (entry.is_flag) begin
                    target = lfr_pkg::PHASE_FLAG;
                end else if (entry.is_control) begin
                    store  = 1'b1;
                    target = lfr_pkg::PHASE_CONTROL;
                end
            end
            lfr_pkg::ST_CONTROL: begin
                if (entry.is_flag) begin
                    target = lfr_pkg::PHASE_FLAG;
                end else if ((address_reg ^ control_reg) == entry.rx_byte) begin
                    store  = 1'b1;
                    target = lfr_pkg::PHASE_CHECKED;
                end
            end
            lfr_pkg::ST_CHECKED, lfr_pkg::ST_DATA: begin
                store  = 1'b1;
                target = entry.is_flag ? lfr_pkg::PHASE_DONE : lfr_pkg::PHASE_DATA;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        position_next = position_reg;
        address_next  = address_reg;
        control_next  = control_reg;
        result_next   = result_reg;
        valid_next    = valid_reg;

        if (result_ready) begin
            valid_next = 1'b0;
        end

        if (entry_pop) begin
            valid_next              = 1'b1;
            result_next             = '0;
            state_next              = lfr_pkg::ST_IDLE;
            position_next           = '0;
            if (store) begin
                if (position_reg >= CAPACITY) begin
                    result_next.overflow = 1'b1;
                end else begin
                    result_next.store_valid    = 1'b1;
                    result_next.store_position = position_ext[lfr_pkg::BYTE_W-1:0];
                    result_next.store_value    = entry.rx_byte;
                    result_next.frame_phase    = target;
                    position_next              = position_reg + 1'b1;
                    case (target)
                        lfr_pkg::PHASE_FLAG: begin
                            state_next = lfr_pkg::ST_FLAG;
                        end
                        lfr_pkg::PHASE_ADDRESS: begin
                            state_next   = lfr_pkg::ST_ADDRESS;
                            address_next = entry.rx_byte;
                        end
                        lfr_pkg::PHASE_CONTROL: begin
                            state_next   = lfr_pkg::ST_CONTROL;
                            control_next = entry.rx_byte;
                        end
                        lfr_pkg::PHASE_CHECKED: begin
                            state_next = lfr_pkg::ST_CHECKED;
                        end
                        lfr_pkg::PHASE_DATA: begin
                            state_next = lfr_pkg::ST_DATA;
                        end
                        default: begin
                            result_next.frame_done = 1'b1;
                            state_next             = lfr_pkg::ST_IDLE;
                            position_next          = '0;
                        end
                    endcase
                end
            end else if (target == lfr_pkg::PHASE_FLAG) begin
                result_next.frame_phase = lfr_pkg::PHASE_FLAG;
                state_next              = lfr_pkg::ST_FLAG;
                position_next           = POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lfr_pkg::ST_IDLE;
            position_reg <= '0;
            address_reg  <= '0;
            control_reg  <= '0;
            valid_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            position_reg <= position_next;
            address_reg  <= address_next;
            control_reg  <= control_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

endmodule

>>> sv/link_frame_receiver_core.sv
`timescale 1ns / 1ps
// Byte-serial receiver for flag-delimited link frames.
// Input channel s_valid/s_ready/s_rx_byte takes one received byte per
// transaction. Every byte yields exactly one transaction on the result
// channel m_valid/m_ready: frame phase, store flag, position and value,
// frame completion and overflow.
// The front classifies each byte against the configured flag, addresses and
// control codes and writes it to a two-entry queue; the back runs the frame
// state machine and loads the result register.
// An accepted byte is stored in the queue, then its result is registered.
// Throughput: one byte per cycle while m_ready is high; a held result stalls it.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write only while idle (not enforced); indexes beyond the list are ignored.
// Reset (aresetn low, synchronous) restores default codes, empties the
// queue, drops any pending result and returns the frame machine to idle.
// When m_ready is low the result holds; the queue absorbs up to two more
// bytes before s_ready drops.
module link_frame_receiver_core #(
    parameter int FRAME_CAPACITY = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [lfr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lfr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [lfr_pkg::BYTE_W-1:0]         s_rx_byte,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [lfr_pkg::PHASE_W-1:0]        m_frame_phase,
    output logic                               m_store_valid,
    output logic [lfr_pkg::BYTE_W-1:0]         m_store_position,
    output logic [lfr_pkg::BYTE_W-1:0]         m_store_value,
    output logic                               m_frame_done,
    output logic                               m_overflow
);

    lfr_pkg::class_entry_t  front_entry;
    lfr_pkg::class_entry_t  head_entry;
    lfr_pkg::frame_result_t result;
    logic                   queue_full;
    logic                   queue_not_empty;
    logic                   queue_pop;
    logic                   push;

    assign s_ready = !queue_full;
    assign push    = s_valid && s_ready;

    lfr_classify u_classify (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx_byte   (s_rx_byte),
        .entry     (front_entry)
    );

    lfr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (front_entry),
        .full       (queue_full),
        .pop        (queue_pop),
        .not_empty  (queue_not_empty),
        .head_entry (head_entry)
    );

    lfr_sequencer #(
        .FRAME_CAPACITY (FRAME_CAPACITY)
    ) u_sequencer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .entry_valid  (queue_not_empty),
        .entry        (head_entry),
        .entry_pop    (queue_pop),
        .result_valid (m_valid),
        .result_ready (m_ready),
        .result       (result)
    );

    assign m_frame_phase    = result.frame_phase;
    assign m_store_valid    = result.store_valid;
    assign m_store_position = result.store_position;
    assign m_store_value    = result.store_value;
    assign m_frame_done     = result.frame_done;
    assign m_overflow       = result.overflow;

endmodule
